### hdl/prescaled_timer_pair_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the prescaled timer pair
// Implication checks, same cycle and next cycle, on the block clock.
// ----------------------------------------------------------------------------
`ifndef PRESCALED_TIMER_PAIR_ASSERT_SVH
`define PRESCALED_TIMER_PAIR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("prescaled_timer_pair: check failed");

// Consequent must hold in the cycle after the antecedent.
`define PTP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("prescaled_timer_pair: check failed");

`endif

### hdl/ptp_pkg.sv
// ----------------------------------------------------------------------------
// ptp_pkg
// Types and constants shared by the prescaled timer pair modules.
// ----------------------------------------------------------------------------
package ptp_pkg;

   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned MODE_W   = 6;
   localparam int unsigned LINE_W   = 16;
   localparam int unsigned EIGHTH_W = 4;

   // prescaler periods in ticks
   localparam int unsigned HSYNC_DIV = 2048;
   localparam int unsigned DIV_T2    = 8;

   localparam logic [COUNT_W:0] COUNT_STEP  = (COUNT_W + 1)'(2);
   localparam logic [COUNT_W:0] COUNT_LIMIT = {1'b0, {COUNT_W{1'b1}}};

   // mode bit positions
   localparam int unsigned MODE_SRC_LO = 0;
   localparam int unsigned MODE_SRC_HI = 1;
   localparam int unsigned MODE_IRQ_TG = 2;
   localparam int unsigned MODE_IRQ_OV = 3;
   localparam int unsigned MODE_HIT_TG = 4;
   localparam int unsigned MODE_HIT_OV = 5;

   // timer select codes
   localparam logic [1:0] SEL_TIMER1 = 2'd1;
   localparam logic [1:0] SEL_TIMER2 = 2'd2;

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_WR_MODE   = 2'd1,
      OP_WR_TARGET = 2'd2,
      OP_RD_COUNT  = 2'd3
   } op_type;

   typedef struct packed {
      op_type             operation;
      logic [1:0]         timer_select;
      logic [COUNT_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] read_data;
      logic               irq_timer_one;
      logic               irq_timer_two;
   } rsp_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] count;
   } timer_type;

endpackage

### hdl/ptp_timer_step.sv
// ----------------------------------------------------------------------------
// ptp_timer_step
// One tick of a counting timer: add, overflow wrap, target match and flags.
// ----------------------------------------------------------------------------
module ptp_timer_step import ptp_pkg::*; (
   input  timer_type          cur_state,
   input  logic [COUNT_W-1:0] target,
   input  logic               add,
   output timer_type          nxt_state,
   output logic               irq
);

   logic [COUNT_W:0]  sum;
   logic [MODE_W-1:0] mode;

   always_comb begin
      sum  = {1'b0, cur_state.count} + (add ? COUNT_STEP : '0);
      mode = cur_state.mode;
      irq  = 1'b0;
      // wrap past 0xFFFE
      if (sum >= COUNT_LIMIT) begin
         mode[MODE_HIT_OV] = 1'b1;
         irq               = mode[MODE_IRQ_OV];
         sum               = '0;
      end
      if (mode[MODE_IRQ_TG] && (target != '0) && (sum >= {1'b0, target})) begin
         mode[MODE_HIT_TG] = 1'b1;
         irq               = 1'b1;
         sum               = '0;
      end
      nxt_state.mode  = mode;
      nxt_state.count = sum[COUNT_W-1:0];
   end

endmodule

### hdl/prescaled_timer_pair.sv
// Requests pass the input register, then the response register. Throughput:
// one item per cycle unless rsp_stall holds; timer state is updated in the same
// cycle the item moves from the input register into the response register.
// Every item yields exactly one response.
// Reset: synchronous, active high; clears all counts, targets, modes,
// prescalers and both valid registers. No clearing pass is needed.
// ----------------------------------------------------------------------------
// prescaled_timer_pair
// Timer 1 and timer 2 with optional prescalers, mode and target registers.
// Timer slot 0 never counts and is never observable, so it holds no storage.
// ----------------------------------------------------------------------------
`include "prescaled_timer_pair_assert.svh"

module prescaled_timer_pair import ptp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic      stg_valid_ff, stg_valid_in;
   req_type   stg_data_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff, rsp_data_in;

   timer_type          timer1_ff, timer1_in;
   timer_type          timer2_ff, timer2_in;
   logic [COUNT_W-1:0] target1_ff, target1_in;
   logic [COUNT_W-1:0] target2_ff, target2_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic [EIGHTH_W-1:0] eighth_ff, eighth_in;

   logic              out_load;
   logic              fire;
   logic              tick;
   logic              pre1, pre2;
   logic [LINE_W:0]   line_sum;
   logic [EIGHTH_W:0] eighth_sum;
   logic              line_wrap, eighth_wrap;
   logic              add1, add2;
   timer_type         step1, step2;
   logic              irq1, irq2;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign fire      = stg_valid_ff && out_load;
   assign req_stall = stg_valid_ff && !out_load;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign stg_valid_in = req_stall ? stg_valid_ff : req_valid;

   assign tick = fire && (stg_data_ff.operation == OP_TICK);
   assign pre1 = timer1_ff.mode[MODE_SRC_LO];
   assign pre2 = timer2_ff.mode[MODE_SRC_HI];

   assign line_sum    = {1'b0, line_ff} + (LINE_W + 1)'(1);
   assign line_wrap   = line_sum >= (LINE_W + 1)'(HSYNC_DIV);
   assign eighth_sum  = {1'b0, eighth_ff} + (EIGHTH_W + 1)'(1);
   assign eighth_wrap = eighth_sum >= (EIGHTH_W + 1)'(DIV_T2);
   assign add1        = !pre1 || line_wrap;
   assign add2        = !pre2 || eighth_wrap;

   ptp_timer_step u_step1 (
      .cur_state (timer1_ff),
      .target    (target1_ff),
      .add       (add1),
      .nxt_state (step1),
      .irq       (irq1)
   );

   ptp_timer_step u_step2 (
      .cur_state (timer2_ff),
      .target    (target2_ff),
      .add       (add2),
      .nxt_state (step2),
      .irq       (irq2)
   );

   always_comb begin
      timer1_in   = timer1_ff;
      timer2_in   = timer2_ff;
      target1_in  = target1_ff;
      target2_in  = target2_ff;
      line_in     = line_ff;
      eighth_in   = eighth_ff;
      rsp_data_in = '0;
      if (fire) begin
         case (stg_data_ff.operation)
            OP_TICK: begin
               timer1_in = step1;
               timer2_in = step2;
               if (pre1) begin
                  line_in = line_wrap ? '0 : line_sum[LINE_W-1:0];
               end
               if (pre2) begin
                  eighth_in = eighth_wrap ? '0 : eighth_sum[EIGHTH_W-1:0];
               end
               rsp_data_in.irq_timer_one = irq1;
               rsp_data_in.irq_timer_two = irq2;
            end
            OP_WR_MODE: begin
               // mode write also restarts the count
               if (stg_data_ff.timer_select == SEL_TIMER1) begin
                  timer1_in.mode  = stg_data_ff.write_value[MODE_W-1:0];
                  timer1_in.count = '0;
               end
               if (stg_data_ff.timer_select == SEL_TIMER2) begin
                  timer2_in.mode  = stg_data_ff.write_value[MODE_W-1:0];
                  timer2_in.count = '0;
               end
            end
            OP_WR_TARGET: begin
               if (stg_data_ff.timer_select == SEL_TIMER1) begin
                  target1_in = stg_data_ff.write_value;
               end
               if (stg_data_ff.timer_select == SEL_TIMER2) begin
                  target2_in = stg_data_ff.write_value;
               end
            end
            OP_RD_COUNT: begin
               if (stg_data_ff.timer_select == SEL_TIMER1) begin
                  rsp_data_in.read_data = timer1_ff.count;
               end else if (stg_data_ff.timer_select == SEL_TIMER2) begin
                  rsp_data_in.read_data = timer2_ff.count;
               end
            end
            default: begin
               rsp_data_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timer1_ff    <= '0;
         timer2_ff    <= '0;
         target1_ff   <= '0;
         target2_ff   <= '0;
         line_ff      <= '0;
         eighth_ff    <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         if (out_load) begin
            rsp_valid_ff <= stg_valid_ff;
         end
         timer1_ff  <= timer1_in;
         timer2_ff  <= timer2_in;
         target1_ff <= target1_in;
         target2_ff <= target2_in;
         line_ff    <= line_in;
         eighth_ff  <= eighth_in;
      end
   end

   // payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         stg_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `PTP_ASSERT_SAME(a_no_load_while_held, rsp_valid_ff && rsp_stall, !fire)
   `PTP_ASSERT_NEXT(a_irq_only_on_tick, fire && (stg_data_ff.operation != OP_TICK),
                    !rsp_data_ff.irq_timer_one && !rsp_data_ff.irq_timer_two)
   `PTP_ASSERT_SAME(a_count_below_limit, 1'b1,
                    (timer1_ff.count != {COUNT_W{1'b1}}) && (timer2_ff.count != {COUNT_W{1'b1}}))
   `PTP_ASSERT_SAME(a_line_below_div, 1'b1, {1'b0, line_ff} < (LINE_W + 1)'(HSYNC_DIV))

endmodule
